[rtl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg: shared definitions for the min-heap priority queue
// Command and status codes, fixed field widths and the controller state type.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;

  // Command codes.
  localparam logic [CmdW-1:0] CmdPush  = 2'd0;
  localparam logic [CmdW-1:0] CmdPop   = 2'd1;
  localparam logic [CmdW-1:0] CmdClear = 2'd2;
  localparam logic [CmdW-1:0] CmdQuery = 2'd3;

  // Status codes.
  localparam logic [StatusW-1:0] StatOk    = 2'd0;
  localparam logic [StatusW-1:0] StatFull  = 2'd1;
  localparam logic [StatusW-1:0] StatEmpty = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UP    = 8'b0000_0010,
    S_UPCMP = 8'b0000_0100,
    S_LAST  = 8'b0000_1000,
    S_DNL   = 8'b0001_0000,
    S_DNR   = 8'b0010_0000,
    S_DNCMP = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

endpackage

[rtl/min_heap_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit: binary min-heap of signed 32-bit values
// Push, pop minimum, clear and query on a fixed-capacity heap that lives in a
// single-port-write, single-port-read synchronous RAM.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// command   in         start_i & !busy_o    cmd_i, value_i
// result    out        done_o (one cycle)   status_o, top_value_o, top_valid_o, count_o
//
// Each heap level costs one RAM read, a compare and a write-back, and a pop
// reads both children through the one read port.
// Reset clears the fill count, the state and the status; heap RAM contents are not cleared.
// The result is shown for one cycle and cannot be stalled; busy_o is high from
// the cycle after accept through the done_o cycle.
module min_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [CmdW-1:0]           cmd_i,
  input  logic signed [ValueW-1:0]  value_i,
  output logic                      done_o,
  output logic [StatusW-1:0]        status_o,
  output logic signed [ValueW-1:0]  top_value_o,
  output logic                      top_valid_o,
  output logic [CountW-1:0]         count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] Cap = CW'(CAPACITY);
  localparam logic [CW-1:0] One = CW'(1);

  state_e                    state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic signed [ValueW-1:0]  val_q, val_d;
  logic signed [ValueW-1:0]  lv_q, lv_d;
  logic [StatusW-1:0]        status_q, status_d;
  logic signed [ValueW-1:0]  top_q;

  // RAM port signals.
  logic                      we;
  logic [CW-1:0]             wslot;
  logic signed [ValueW-1:0]  wdata;
  logic [CW-1:0]             rslot;
  logic signed [ValueW-1:0]  rdata_q;
  logic signed [ValueW-1:0]  mem [CAPACITY];

  // Child positions of the current hole, one bit wider than the count.
  logic [CW:0] left_w, right_w;
  logic        has_l, has_r;

  assign left_w  = {idx_q, 1'b0};
  assign right_w = left_w + (CW+1)'(1);
  assign has_l   = left_w <= {1'b0, cnt_q};
  assign has_r   = right_w <= {1'b0, cnt_q};

  // Heap RAM: slot k lives at address k-1, read data registered.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[IW'(wslot - One)] <= wdata;
    end
    rdata_q <= mem[IW'(rslot - One)];
  end

  // Next-state logic of the sift sequencer.
  always_comb begin
    logic signed [ValueW-1:0] sv;
    logic [CW-1:0]            s;
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    val_d    = val_q;
    lv_d     = lv_q;
    status_d = status_q;
    we       = 1'b0;
    wslot    = idx_q;
    wdata    = val_q;
    rslot    = idx_q;
    sv       = val_q;
    s        = idx_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = StatOk;
          state_d  = S_DONE;
          case (cmd_i)
            CmdPush: begin
              if (cnt_q == Cap) begin
                status_d = StatFull;
              end else begin
                cnt_d   = cnt_q + One;
                idx_d   = cnt_q + One;
                val_d   = value_i;
                state_d = S_UP;
              end
            end
            CmdPop: begin
              if (cnt_q == '0) begin
                status_d = StatEmpty;
              end else begin
                rslot   = cnt_q;
                cnt_d   = cnt_q - One;
                idx_d   = One;
                state_d = S_LAST;
              end
            end
            CmdClear: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // Sift up: fetch the parent of the hole, or settle at the root.
      S_UP: begin
        if (idx_q == One) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          rslot   = idx_q >> 1;
          state_d = S_UPCMP;
        end
      end
      // Move a strictly greater parent down into the hole.
      S_UPCMP: begin
        we = 1'b1;
        if (val_q < rdata_q) begin
          wdata   = rdata_q;
          idx_d   = idx_q >> 1;
          state_d = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      // The last entry becomes the value sifted down from the root.
      S_LAST: begin
        val_d   = rdata_q;
        state_d = (cnt_q == '0) ? S_DONE : S_DNL;
      end
      // Sift down: fetch the left child, or settle at a leaf.
      S_DNL: begin
        if (has_l) begin
          rslot   = left_w[CW-1:0];
          state_d = S_DNR;
        end else begin
          we      = 1'b1;
          state_d = S_DONE;
        end
      end
      // Keep the left child and fetch the right one; it is used only when it exists.
      S_DNR: begin
        lv_d    = rdata_q;
        rslot   = right_w[CW-1:0];
        state_d = S_DNCMP;
      end
      // Pick the strictly smallest of hole value and children, left wins ties.
      S_DNCMP: begin
        if (lv_q < sv) begin
          sv = lv_q;
          s  = left_w[CW-1:0];
        end
        if (has_r && (rdata_q < sv)) begin
          sv = rdata_q;
          s  = right_w[CW-1:0];
        end
        we = 1'b1;
        if (s == idx_q) begin
          state_d = S_DONE;
        end else begin
          wdata   = sv;
          idx_d   = s;
          state_d = S_DNL;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      status_q <= StatOk;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  // Datapath registers; the root copy follows every write to slot one.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
    lv_q  <= lv_d;
    if (we && (wslot == One)) begin
      top_q <= wdata;
    end
  end

  // Result ports.
  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign status_o    = status_q;
  assign top_valid_o = (cnt_q != '0);
  assign top_value_o = (cnt_q != '0) ? top_q : '0;
  assign count_o     = CountW'(cnt_q);

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Cap)
    else $error("fill count above capacity");

  // An accepted command always makes the unit busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not start work");

  // The RAM is written only while a command is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (busy_o && !done_o))
    else $error("heap write outside a command");

  // After a result the unit is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_o)
    else $error("unit stuck busy after a result");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for min_heap_priority_queue_unit
// Drives push, pop, clear and query commands in random bursts, keeps a shadow
// heap that predicts every result, and compares each done_o strobe field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import mhpq_pkg::*;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ItemTarget = 1450;

  // One command item as it goes onto the ports.
  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [ValueW-1:0] value;
  } heap_cmd_t;

  // One expected result.
  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] top_value;
    logic                     top_valid;
    logic [CountW-1:0]        count;
  } heap_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [CmdW-1:0]          cmd_i = CmdQuery;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [StatusW-1:0]       status_o;
  logic signed [ValueW-1:0] top_value_o;
  logic                     top_valid_o;
  logic [CountW-1:0]        count_o;

  min_heap_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .top_value_o (top_value_o),
    .top_valid_o (top_valid_o),
    .count_o     (count_o)
  );

  always #2 clk_i = ~clk_i;

  // Hold reset at start-up, then release it at a falling edge.
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  heap_cmd_t    cmd_backlog[$];
  heap_result_t pending_results[$];
  int unsigned  failures = 0;
  int unsigned  planned_items = 0;
  int unsigned  planned_fill = 0;

  // Shadow copy of the heap used to predict each result.
  logic signed [ValueW-1:0] shadow_heap [1:CAPACITY];
  int unsigned              shadow_fill = 0;

  // Apply one command to the shadow heap and return the result it gives.
  function automatic heap_result_t apply_heap_cmd(logic [CmdW-1:0] cmd,
                                                  logic signed [ValueW-1:0] val);
    heap_result_t             res;
    int unsigned              idx;
    int unsigned              lchild;
    int unsigned              rchild;
    int unsigned              least;
    logic signed [ValueW-1:0] tmp;
    bit                       settled;
    res.status = StatOk;
    case (cmd)
      CmdPush: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = StatFull;
        end else begin
          // Place last, then sift up while the parent is strictly greater.
          shadow_fill++;
          idx = shadow_fill;
          shadow_heap[idx] = val;
          while (idx > 1 && shadow_heap[idx] < shadow_heap[idx / 2]) begin
            tmp = shadow_heap[idx];
            shadow_heap[idx] = shadow_heap[idx / 2];
            shadow_heap[idx / 2] = tmp;
            idx = idx / 2;
          end
        end
      end
      CmdPop: begin
        if (shadow_fill == 0) begin
          res.status = StatEmpty;
        end else begin
          // Move the last entry to the root and sift down; the left child wins ties.
          shadow_heap[1] = shadow_heap[shadow_fill];
          shadow_fill--;
          idx = 1;
          settled = 1'b0;
          while (!settled) begin
            lchild = 2 * idx;
            rchild = lchild + 1;
            least = idx;
            if (lchild <= shadow_fill && shadow_heap[lchild] < shadow_heap[least]) begin
              least = lchild;
            end
            if (rchild <= shadow_fill && shadow_heap[rchild] < shadow_heap[least]) begin
              least = rchild;
            end
            if (least == idx) begin
              settled = 1'b1;
            end else begin
              tmp = shadow_heap[idx];
              shadow_heap[idx] = shadow_heap[least];
              shadow_heap[least] = tmp;
              idx = least;
            end
          end
        end
      end
      CmdClear: begin
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    res.top_valid = (shadow_fill > 0);
    res.top_value = (shadow_fill > 0) ? shadow_heap[1] : '0;
    res.count = CountW'(shadow_fill);
    return res;
  endfunction

  // Queue one item and track the fill level the stimulus expects.
  task automatic add_item(logic [CmdW-1:0] cmd, logic signed [ValueW-1:0] val);
    cmd_backlog.push_back('{cmd: cmd, value: val});
    planned_items++;
    case (cmd)
      CmdPush:  if (planned_fill < CAPACITY) planned_fill++;
      CmdPop:   if (planned_fill > 0) planned_fill--;
      CmdClear: planned_fill = 0;
      default: ;
    endcase
  endtask

  // Random value with a bias toward ties and the signed extremes.
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $signed(ValueW'($urandom_range(0, 6))) - 3;
      1: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed(ValueW'($urandom));
    endcase
  endfunction

  // Build the stimulus: a directed opening, then random episodes.
  initial begin
    int unsigned episode;
    int unsigned len;
    int unsigned pick;

    // Empty heap: query, pop on empty, clear.
    add_item(CmdQuery, 32'sd0);
    add_item(CmdPop, 32'sd0);
    add_item(CmdClear, -32'sd1);
    // Extremes and ties, then a query, pops, a clear and a pop on empty.
    add_item(CmdPush, 32'sd0);
    add_item(CmdPush, 32'sh7FFF_FFFF);
    add_item(CmdPush, 32'sh8000_0000);
    add_item(CmdPush, -32'sd1);
    add_item(CmdPush, 32'sd1);
    add_item(CmdPush, -32'sd1);
    add_item(CmdPush, 32'sh8000_0000);
    add_item(CmdQuery, 32'sh5555_5555);
    add_item(CmdPop, 32'sh2AAA_AAAA);
    add_item(CmdPop, 32'sd0);
    add_item(CmdPop, 32'sd0);
    add_item(CmdPop, 32'sd0);
    add_item(CmdPush, 32'sd5);
    add_item(CmdClear, 32'sd0);
    add_item(CmdQuery, 32'sd0);
    add_item(CmdPop, 32'sd0);
    add_item(CmdPush, 32'sh7FFF_FFFF);
    add_item(CmdPop, 32'sd0);

    // The first random episodes fill the heap past full, then drain it past empty.
    episode = 1;
    while (planned_items < ItemTarget) begin
      case (episode)
        1: begin
          len = $urandom_range(1, 4);
          while (planned_fill < CAPACITY) add_item(CmdPush, pick_value());
          repeat (len) add_item(CmdPush, pick_value());
        end
        2: begin
          len = $urandom_range(1, 3);
          while (planned_fill > 0) add_item(CmdPop, pick_value());
          repeat (len) add_item(CmdPop, pick_value());
        end
        3: begin
          add_item(CmdClear, pick_value());
          repeat ($urandom_range(1, 20)) add_item(CmdPush, pick_value());
        end
        default: begin
          // Mixed traffic that leans toward growth.
          repeat ($urandom_range(10, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) add_item(CmdPush, pick_value());
            else if (pick < 85) add_item(CmdPop, pick_value());
            else if (pick < 97) add_item(CmdQuery, pick_value());
            else add_item(CmdClear, pick_value());
          end
        end
      endcase
      episode = (planned_items < 600 && episode < 2) ? episode + 1 : $urandom_range(0, 4);
    end
  end

  // Driver: items go out in bursts with random gaps, changing at the falling edge.
  bit          item_held = 1'b0;
  bit          item_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  heap_cmd_t   next_item;

  always @(negedge clk_i) begin
    if (rst_ni && !(item_held && !item_taken)) begin
      if (item_held) begin
        item_held = 1'b0;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      if (gap_left == 0 && cmd_backlog.size() != 0) begin
        next_item = cmd_backlog.pop_front();
        start_i <= 1'b1;
        cmd_i <= next_item.cmd;
        value_i <= next_item.value;
        item_held = 1'b1;
      end else begin
        // Idle cycle: the data lines carry noise the block must ignore.
        if (gap_left > 0) gap_left--;
        start_i <= 1'b0;
        cmd_i <= CmdW'($urandom_range(0, 3));
        value_i <= $signed(ValueW'($urandom));
      end
    end
  end

  // Monitor: check results and record accepted items at the rising edge.
  heap_result_t predicted;

  always @(posedge clk_i) begin
    item_taken = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding");
          failures++;
        end else begin
          predicted = pending_results.pop_front();
          if (status_o !== predicted.status) begin
            $error("status: expected %0d, got %0d", predicted.status, status_o);
            failures++;
          end
          if (top_value_o !== predicted.top_value) begin
            $error("top_value: expected %0d, got %0d", predicted.top_value, top_value_o);
            failures++;
          end
          if (top_valid_o !== predicted.top_valid) begin
            $error("top_valid: expected %0d, got %0d", predicted.top_valid, top_valid_o);
            failures++;
          end
          if (count_o !== predicted.count) begin
            $error("count: expected %0d, got %0d", predicted.count, count_o);
            failures++;
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        item_taken = 1'b1;
        pending_results.push_back(apply_heap_cmd(cmd_i, value_i));
      end
    end
  end

  // Wait for the last result, leave room for stray strobes, then report.
  initial begin
    wait (rst_ni);
    while (cmd_backlog.size() != 0 || item_held || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/mhpq_pkg.sv
rtl/min_heap_priority_queue_unit.sv
sim/tb_top.sv
